// ----- hw/rtl/rlt_pkg.sv -----
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and constants of the rule line tokenizer
// Character codes, result kinds, status codes, the parser flag set and the result item.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Record end status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_EOI       = 2'd2;

  // Characters that the rules look for.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Single-bit parser flags.
  typedef struct packed {
    logic command_side;
    logic escape_pending;
    logic in_comment;
    logic in_quote;
    logic arrow_started;
    logic malformed;
  } flags_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [1:0] status;
  } result_t;

endpackage

// ----- hw/rtl/rlt_if.sv -----
// ----------------------------------------------------------------------------
// rlt_if: request channels of the rule line tokenizer
// Input channel carries one character or an end mark; output channel one token.
// ----------------------------------------------------------------------------
interface rlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface rlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [1:0] status;

  modport source (output valid, output kind, output char_out, output status, input ready);
  modport sink (input valid, input kind, input char_out, input status, output ready);
endinterface

// ----- hw/rtl/rlt_rules.sv -----
// ----------------------------------------------------------------------------
// rlt_rules: per-character rule evaluation
// Computes the next parser state and the optional result for one character.
// ----------------------------------------------------------------------------
module rlt_rules #(
  parameter int NAME_LIMIT    = 24,
  parameter int COMMAND_LIMIT = 2048
) (
  input  logic [7:0]                         byte_in,
  input  logic                               end_of_input,
  input  rlt_pkg::flags_t                    flags,
  input  logic [$clog2(NAME_LIMIT)-1:0]      name_length,
  input  logic [$clog2(COMMAND_LIMIT)-1:0]   command_length,
  output rlt_pkg::flags_t                    flags_next,
  output logic [$clog2(NAME_LIMIT)-1:0]      name_length_next,
  output logic [$clog2(COMMAND_LIMIT)-1:0]   command_length_next,
  output logic                               emit,
  output rlt_pkg::result_t                   result
);

  localparam int NW = $clog2(NAME_LIMIT);
  localparam int CW = $clog2(COMMAND_LIMIT);
  localparam logic [NW-1:0] NAME_MAX    = NW'(NAME_LIMIT - 1);
  localparam logic [CW-1:0] COMMAND_MAX = CW'(COMMAND_LIMIT - 1);

  logic clear_escape;
  logic is_blank;

  assign is_blank = (byte_in == rlt_pkg::CH_SPACE) || (byte_in == rlt_pkg::CH_TAB);

  always_comb begin
    flags_next          = flags;
    name_length_next    = name_length;
    command_length_next = command_length;
    emit                = 1'b0;
    result              = '{kind: rlt_pkg::KIND_END, char_out: 8'd0,
                            status: rlt_pkg::STATUS_OK};
    clear_escape        = 1'b0;

    priority if (end_of_input) begin
      flags_next          = '0;
      name_length_next    = '0;
      command_length_next = '0;
      emit                = 1'b1;
      result.status       = rlt_pkg::STATUS_EOI;
    end else if (byte_in == rlt_pkg::CH_SEMI) begin
      flags_next          = '0;
      name_length_next    = '0;
      command_length_next = '0;
      emit                = 1'b1;
      result.status       = flags.malformed ? rlt_pkg::STATUS_MALFORMED
                                            : rlt_pkg::STATUS_OK;
    end else if (flags.malformed) begin
      // Everything up to the semicolon is dropped.
    end else begin
      clear_escape = 1'b1;
      priority if (byte_in == rlt_pkg::CH_NL) begin
        flags_next.in_comment = 1'b0;
        if (flags.in_quote) begin
          flags_next.malformed = 1'b1;
        end
      end else if (flags.in_comment) begin
        clear_escape = 1'b0;
      end else if (byte_in == rlt_pkg::CH_BSLASH) begin
        flags_next.escape_pending = 1'b1;
        clear_escape              = 1'b0;
      end else if (byte_in == rlt_pkg::CH_QUOTE && !flags.escape_pending) begin
        flags_next.in_quote = !flags.in_quote;
      end else if (!flags.in_quote && byte_in == rlt_pkg::CH_HASH) begin
        flags_next.in_comment = 1'b1;
      end else if (!flags.in_quote && !flags.arrow_started && is_blank) begin
        clear_escape = 1'b0;
      end else if (flags.in_quote && !flags.command_side && name_length < NAME_MAX) begin
        name_length_next = name_length + NW'(1);
        emit             = 1'b1;
        result           = '{kind: rlt_pkg::KIND_NAME, char_out: byte_in,
                             status: rlt_pkg::STATUS_OK};
      end else if (byte_in == rlt_pkg::CH_DASH && !flags.in_quote) begin
        flags_next.arrow_started = 1'b1;
      end else if (flags.arrow_started && byte_in == rlt_pkg::CH_GT &&
                   !flags.command_side && name_length != '0) begin
        flags_next.command_side  = 1'b1;
        flags_next.arrow_started = 1'b0;
      end else if (flags.in_quote && flags.command_side &&
                   command_length < COMMAND_MAX) begin
        command_length_next = command_length + CW'(1);
        emit                = 1'b1;
        result              = '{kind: rlt_pkg::KIND_COMMAND, char_out: byte_in,
                                status: rlt_pkg::STATUS_OK};
      end else begin
        flags_next.malformed = 1'b1;
      end
      if (clear_escape) begin
        flags_next.escape_pending = 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/rule_line_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// rule_line_tokenizer_top: byte-serial parser for 'name' -> 'command'; records
// Registers each character, applies the parsing rules and emits tokens.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Payload                          Request meaning
//   char_in    in   byte_in[7:0], end_of_input       one character or end mark
//   token_out  out  kind[1:0], char_out[7:0],        name/command character or
//                   status[1:0]                      record end with status
//
// One request per cycle is taken in steady state while tokens are taken.
// A character is captured in the input register when it is accepted, the rule
// logic evaluates it there, and its token (if any) is loaded into the result
// register when the rule stage advances; the token is visible from the result
// register.
// The parser state (flags and both length counters) is updated in the same
// cycle as the result register, which keeps consecutive characters in order.
// When the result register holds a token that is not taken, the pipeline
// stalls as a whole; the input register still accepts while it is empty.
// Reset (rst, synchronous, active high) clears the parser state and both
// valid bits; no clearing pass is needed.
module rule_line_tokenizer_top #(
  parameter int NAME_LIMIT    = 24,
  parameter int COMMAND_LIMIT = 2048
) (
  input logic         clk,
  input logic         rst,
  rlt_in_if.sink      char_in,
  rlt_out_if.source   token_out
);

  localparam int NW = $clog2(NAME_LIMIT);
  localparam int CW = $clog2(COMMAND_LIMIT);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;

  // Parser state.
  rlt_pkg::flags_t flags;
  rlt_pkg::flags_t flags_next;
  logic [NW-1:0]   name_length;
  logic [NW-1:0]   name_length_next;
  logic [CW-1:0]   command_length;
  logic [CW-1:0]   command_length_next;

  // Result register.
  logic             res_valid;
  rlt_pkg::result_t res;
  rlt_pkg::result_t res_next;
  logic             emit;

  // The rule stage moves forward whenever the result register is free or is
  // being drained this cycle.
  logic advance;

  assign advance       = !res_valid || token_out.ready;
  assign char_in.ready = !in_valid || advance;

  rlt_rules #(
    .NAME_LIMIT    (NAME_LIMIT),
    .COMMAND_LIMIT (COMMAND_LIMIT)
  ) u_rules (
    .byte_in             (in_byte),
    .end_of_input        (in_eoi),
    .flags               (flags),
    .name_length         (name_length),
    .command_length      (command_length),
    .flags_next          (flags_next),
    .name_length_next    (name_length_next),
    .command_length_next (command_length_next),
    .emit                (emit),
    .result              (res_next)
  );

  // Input register: payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
    if (char_in.ready && char_in.valid) begin
      in_byte <= char_in.byte_in;
      in_eoi  <= char_in.end_of_input;
    end
  end

  // Parser state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags          <= '0;
      name_length    <= '0;
      command_length <= '0;
      res_valid      <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && emit;
      if (in_valid) begin
        flags          <= flags_next;
        name_length    <= name_length_next;
        command_length <= command_length_next;
      end
    end
    if (advance && in_valid && emit) begin
      res <= res_next;
    end
  end

  assign token_out.valid    = res_valid;
  assign token_out.kind     = res.kind;
  assign token_out.char_out = res.char_out;
  assign token_out.status   = res.status;

  // The command side is only entered after a non-empty name.
  a_side_needs_name: assert property (@(posedge clk) disable iff (rst)
    flags.command_side |-> (name_length != '0))
    else $error("command side reached with an empty name");

  // A comment can only open outside a quote, and a quote cannot open in it.
  a_comment_not_quoted: assert property (@(posedge clk) disable iff (rst)
    flags.in_comment |-> !flags.in_quote)
    else $error("comment and quote active together");

  // Character tokens carry an ok status; record ends carry no character.
  a_token_shape: assert property (@(posedge clk) disable iff (rst)
    token_out.valid |->
      ((token_out.kind == rlt_pkg::KIND_END && token_out.char_out == 8'd0) ||
       ((token_out.kind == rlt_pkg::KIND_NAME || token_out.kind == rlt_pkg::KIND_COMMAND) &&
        token_out.status == rlt_pkg::STATUS_OK)))
    else $error("malformed token on output");

  // A held token must not change while it waits.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && !token_out.ready) |=> (token_out.valid && $stable(res)))
    else $error("stalled token changed");

endmodule
